### rtl/jcq_pkg.sv
// ----------------------------------------------------------------------------
// jcq_pkg
// Shared types, register codes, base tables and fixed-point constants of the
// jpeg coefficient quantizer.
// ----------------------------------------------------------------------------
package jcq_pkg;

    localparam int INDEX_W     = 6;
    localparam int COEFF_W     = 16;
    localparam int RESULT_W    = 24;
    localparam int STEP_W      = 8;
    localparam int QUALITY_W   = 7;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 7;

    localparam int FRAC_BITS = 4;
    localparam int STEP_MAX  = 255;

    localparam logic [QUALITY_W-1:0] QUALITY_RESET = 7'd50;

    // scaled entry: (base*scale + 50) / 100, exact by reciprocal below the clamp
    localparam int PROD_W            = 20;
    localparam int DIV100_IN_W       = 15;
    localparam int DIV100_SHIFT      = 22;
    localparam logic [15:0] DIV100_RECIP = 16'(((1 << DIV100_SHIFT) + 99) / 100);
    localparam logic [PROD_W-1:0] PROD_ROUND = 20'd50;
    localparam logic [PROD_W-1:0] PROD_FLOOR = 20'd100;
    localparam logic [PROD_W-1:0] PROD_CLAMP = 20'(100 * (STEP_MAX + 1));

    // quantize divide: magnitude word times ceil(2^RECIP_SHIFT / q)
    localparam int MAG_W        = COEFF_W - FRAC_BITS;
    localparam int RECIP_SHIFT  = 20;
    localparam int RECIP_W      = RECIP_SHIFT + 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_QUALITY      = 2'd0,
        CFG_TABLE_SELECT = 2'd1,
        CFG_DIRECTION    = 2'd2
    } cfg_reg_t;

    typedef enum logic {
        DIR_QUANTIZE   = 1'b0,
        DIR_DEQUANTIZE = 1'b1
    } direction_t;

    typedef enum logic {
        TAB_LUMA   = 1'b0,
        TAB_CHROMA = 1'b1
    } table_t;

    typedef struct packed {
        logic [QUALITY_W-1:0] quality;
        table_t               table_select;
        direction_t           direction;
    } cfg_t;

    typedef struct packed {
        logic        [STEP_W-1:0]  step;
        logic signed [COEFF_W-1:0] coefficient;
        direction_t                direction;
    } step_word_t;

    localparam logic [6:0] LUMA_BASE [64] = '{
        7'd16,  7'd11,  7'd10,  7'd16,  7'd24,  7'd40,  7'd51,  7'd61,
        7'd12,  7'd12,  7'd14,  7'd19,  7'd26,  7'd58,  7'd60,  7'd55,
        7'd14,  7'd13,  7'd16,  7'd24,  7'd40,  7'd57,  7'd69,  7'd56,
        7'd14,  7'd17,  7'd22,  7'd29,  7'd51,  7'd87,  7'd80,  7'd62,
        7'd18,  7'd22,  7'd37,  7'd56,  7'd68,  7'd109, 7'd103, 7'd77,
        7'd24,  7'd35,  7'd55,  7'd64,  7'd81,  7'd104, 7'd113, 7'd92,
        7'd49,  7'd64,  7'd78,  7'd87,  7'd103, 7'd121, 7'd120, 7'd101,
        7'd72,  7'd92,  7'd95,  7'd98,  7'd112, 7'd100, 7'd103, 7'd99
    };

    localparam logic [6:0] CHROMA_BASE [64] = '{
        7'd17, 7'd18, 7'd24, 7'd47, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd18, 7'd21, 7'd26, 7'd66, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd24, 7'd26, 7'd56, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd47, 7'd66, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99
    };

endpackage

### rtl/jpeg_coefficient_quantizer.sv
// ----------------------------------------------------------------------------
// jpeg_coefficient_quantizer
// Quantizes or dequantizes 8x8 block coefficients with a quality-scaled
// standard luma or chroma step table.
// ----------------------------------------------------------------------------
// path: an accepted word passes front stages a and b, the queue, then back stages c and o
// throughput: one word per cycle while out_ready holds high; the front step multiply and
//   the back reciprocal multiply are each one pipeline stage, with a 4-entry queue between
// reset: all pipeline and queue control clears; quality 50, luma table, quantize
// config writes complete in the cycle they are presented
module jpeg_coefficient_quantizer (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic        [jcq_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic        [jcq_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic        [jcq_pkg::INDEX_W-1:0]     coeff_index,
    input  logic signed [jcq_pkg::COEFF_W-1:0]     coefficient,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [jcq_pkg::RESULT_W-1:0]    result_value,
    output logic        [jcq_pkg::STEP_W-1:0]      step_size
);

    jcq_pkg::cfg_t       cfg_reg;
    jcq_pkg::cfg_t       cfg_next;
    logic                push_valid;
    logic                push_ready;
    jcq_pkg::step_word_t push_word;
    logic                pop_valid;
    logic                pop_ready;
    jcq_pkg::step_word_t pop_word;
    logic [3:0]          in_flight_reg;
    logic [3:0]          in_flight_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (jcq_pkg::cfg_reg_t'(cfg_index))
                jcq_pkg::CFG_QUALITY:      cfg_next.quality      = cfg_data;
                jcq_pkg::CFG_TABLE_SELECT: cfg_next.table_select = jcq_pkg::table_t'(cfg_data[0]);
                jcq_pkg::CFG_DIRECTION:    cfg_next.direction    = jcq_pkg::direction_t'(cfg_data[0]);
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.quality      <= jcq_pkg::QUALITY_RESET;
            cfg_reg.table_select <= jcq_pkg::TAB_LUMA;
            cfg_reg.direction    <= jcq_pkg::DIR_QUANTIZE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    jcq_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .coeff_index (coeff_index),
        .coefficient (coefficient),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_word   (push_word)
    );

    jcq_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_word  (push_word),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_word   (pop_word)
    );

    jcq_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_word     (pop_word),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_value (result_value),
        .step_size    (step_size)
    );

    // words accepted but not yet delivered
    assign in_flight_next = in_flight_reg + 4'(in_valid && in_ready) - 4'(out_valid && out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_flight_reg <= '0;
        end
        else
        begin
            in_flight_reg <= in_flight_next;
        end
    end

    // two front stages, the queue, and two back stages
    a_in_flight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        in_flight_reg <= 4'd8)
        else $error("more words in flight than the pipeline can hold");

    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_flight_reg == 4'd0) |-> !out_valid)
        else $error("result word presented with nothing in flight");

    a_step_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> (push_word.step != '0))
        else $error("zero step size handed to the queue");

endmodule

### rtl/jcq_front.sv
// ----------------------------------------------------------------------------
// jcq_front
// Takes coefficient words and works out the quality-scaled step size for
// each one in two stages, then hands the word to the queue.
// ----------------------------------------------------------------------------
module jcq_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  jcq_pkg::cfg_t                      cfg,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic        [jcq_pkg::INDEX_W-1:0] coeff_index,
    input  logic signed [jcq_pkg::COEFF_W-1:0] coefficient,
    output logic                               push_valid,
    input  logic                               push_ready,
    output jcq_pkg::step_word_t                push_word
);

    logic [12:0] scale_rom [128];

    logic                               a_valid_reg;
    logic                               a_valid_next;
    logic        [jcq_pkg::INDEX_W-1:0] a_index_reg;
    logic signed [jcq_pkg::COEFF_W-1:0] a_coeff_reg;
    logic                               b_valid_reg;
    logic                               b_valid_next;
    logic        [jcq_pkg::PROD_W-1:0]  b_prod_reg;
    logic signed [jcq_pkg::COEFF_W-1:0] b_coeff_reg;

    logic                               a_advance;
    logic                               b_advance;
    logic [6:0]                         base;
    logic [jcq_pkg::PROD_W-1:0]         prod;
    logic [30:0]                        quot_full;
    logic [jcq_pkg::STEP_W-1:0]         step;

    // scale per quality code, quality clamped to 1..100
    for (genvar g = 0; g < 128; g++)
    begin : gen_scale
        localparam int QF    = (g < 1) ? 1 : ((g > 100) ? 100 : g);
        localparam int SCALE = (QF < 50) ? (5000 / QF) : (200 - 2 * QF);
        assign scale_rom[g] = 13'(SCALE);
    end

    assign b_advance = !b_valid_reg || push_ready;
    assign a_advance = !a_valid_reg || b_advance;
    assign in_ready  = a_advance;

    assign a_valid_next = a_advance ? in_valid : a_valid_reg;
    assign b_valid_next = b_advance ? a_valid_reg : b_valid_reg;

    always_comb
    begin
        if (cfg.table_select == jcq_pkg::TAB_CHROMA)
        begin
            base = jcq_pkg::CHROMA_BASE[a_index_reg];
        end
        else
        begin
            base = jcq_pkg::LUMA_BASE[a_index_reg];
        end
        prod = jcq_pkg::PROD_W'(base) * jcq_pkg::PROD_W'(scale_rom[cfg.quality])
               + jcq_pkg::PROD_ROUND;
    end

    // divide by 100 is only needed below the clamp point
    always_comb
    begin
        quot_full = 31'(b_prod_reg[jcq_pkg::DIV100_IN_W-1:0]) * 31'(jcq_pkg::DIV100_RECIP);
        priority if (b_prod_reg >= jcq_pkg::PROD_CLAMP)
        begin
            step = jcq_pkg::STEP_W'(jcq_pkg::STEP_MAX);
        end
        else if (b_prod_reg < jcq_pkg::PROD_FLOOR)
        begin
            step = jcq_pkg::STEP_W'(1);
        end
        else
        begin
            step = quot_full[jcq_pkg::DIV100_SHIFT +: jcq_pkg::STEP_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && a_advance)
        begin
            a_index_reg <= coeff_index;
            a_coeff_reg <= coefficient;
        end
        if (a_valid_reg && b_advance)
        begin
            b_prod_reg  <= prod;
            b_coeff_reg <= a_coeff_reg;
        end
    end

    assign push_valid            = b_valid_reg;
    assign push_word.step        = step;
    assign push_word.coefficient = b_coeff_reg;
    assign push_word.direction   = cfg.direction;

endmodule

### rtl/jcq_queue.sv
// ----------------------------------------------------------------------------
// jcq_queue
// Short first-in first-out queue of step words between the front and the
// back, so that either side can stall without stopping the other.
// ----------------------------------------------------------------------------
module jcq_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  jcq_pkg::step_word_t push_word,
    output logic                pop_valid,
    input  logic                pop_ready,
    output jcq_pkg::step_word_t pop_word
);

    jcq_pkg::step_word_t                 entry_reg [jcq_pkg::QUEUE_DEPTH];
    logic [jcq_pkg::QUEUE_PTR_W-1:0]     wr_ptr_reg;
    logic [jcq_pkg::QUEUE_PTR_W-1:0]     wr_ptr_next;
    logic [jcq_pkg::QUEUE_PTR_W-1:0]     rd_ptr_reg;
    logic [jcq_pkg::QUEUE_PTR_W-1:0]     rd_ptr_next;
    logic [jcq_pkg::QUEUE_CNT_W-1:0]     count_reg;
    logic [jcq_pkg::QUEUE_CNT_W-1:0]     count_next;
    logic                                push;
    logic                                pop;

    assign push_ready = count_reg != jcq_pkg::QUEUE_CNT_W'(jcq_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_word   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + jcq_pkg::QUEUE_CNT_W'(push)
                      - jcq_pkg::QUEUE_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

### rtl/jcq_back.sv
// ----------------------------------------------------------------------------
// jcq_back
// Carries out quantize (rounded divide by the step, done as a reciprocal
// multiply) or dequantize (multiply by the step) and holds the result word.
// ----------------------------------------------------------------------------
module jcq_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                pop_valid,
    output logic                                pop_ready,
    input  jcq_pkg::step_word_t                 pop_word,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [jcq_pkg::RESULT_W-1:0] result_value,
    output logic        [jcq_pkg::STEP_W-1:0]   step_size
);

    logic [jcq_pkg::RECIP_W-1:0] recip_rom [256];

    logic                                c_valid_reg;
    logic                                c_valid_next;
    jcq_pkg::step_word_t                 c_word_reg;
    logic        [jcq_pkg::MAG_W-1:0]    c_mag_reg;
    logic                                c_neg_reg;
    logic        [jcq_pkg::RECIP_W-1:0]  c_recip_reg;
    logic                                o_valid_reg;
    logic                                o_valid_next;
    logic signed [jcq_pkg::RESULT_W-1:0] o_result_reg;
    logic        [jcq_pkg::STEP_W-1:0]   o_step_reg;

    logic                                c_advance;
    logic                                o_advance;
    logic signed [jcq_pkg::COEFF_W:0]    coeff_ext;
    logic signed [jcq_pkg::COEFF_W:0]    half_ext;
    logic signed [jcq_pkg::COEFF_W:0]    num;
    logic signed [jcq_pkg::COEFF_W:0]    num_shr;
    logic        [jcq_pkg::MAG_W-1:0]    mag;
    logic [jcq_pkg::MAG_W+jcq_pkg::RECIP_W-1:0] quo_full;
    logic        [jcq_pkg::RESULT_W-1:0] quo_ext;
    logic signed [jcq_pkg::RESULT_W:0]   deq_full;
    logic signed [jcq_pkg::RESULT_W-1:0] result;

    // ceil(2^RECIP_SHIFT / q); exact floor for magnitudes below 2^MAG_W
    for (genvar g = 0; g < 256; g++) begin : gen_recip
        localparam int RECIP = (g == 0) ? 0 : (((1 << jcq_pkg::RECIP_SHIFT) + g - 1) / g);
        assign recip_rom[g] = jcq_pkg::RECIP_W'(RECIP);
    end

    assign o_advance = !o_valid_reg || out_ready;
    assign c_advance = !c_valid_reg || o_advance;
    assign pop_ready = c_advance;

    assign c_valid_next = c_advance ? pop_valid : c_valid_reg;
    assign o_valid_next = o_advance ? c_valid_reg : o_valid_reg;

    // m = floor((c + q*2^(F-1)) / 2^F), then floor(m/q) on m, or on ~m with sign fix if m < 0
    always_comb
    begin
        coeff_ext = (jcq_pkg::COEFF_W + 1)'(pop_word.coefficient);
        half_ext  = (jcq_pkg::COEFF_W + 1)'({pop_word.step, {(jcq_pkg::FRAC_BITS - 1){1'b0}}});
        num       = coeff_ext + half_ext;
        num_shr   = num >>> jcq_pkg::FRAC_BITS;
        // for negative m, ~m is -m-1
        if (num[jcq_pkg::COEFF_W])
        begin
            mag = ~num_shr[jcq_pkg::MAG_W-1:0];
        end
        else
        begin
            mag = num_shr[jcq_pkg::MAG_W-1:0];
        end
    end

    always_comb
    begin
        quo_full = c_mag_reg * c_recip_reg;
        quo_ext  = jcq_pkg::RESULT_W'(quo_full[jcq_pkg::RECIP_SHIFT +: jcq_pkg::MAG_W]);
        deq_full = c_word_reg.coefficient * $signed({1'b0, c_word_reg.step});
        if (c_word_reg.direction == jcq_pkg::DIR_DEQUANTIZE)
        begin
            result = deq_full[jcq_pkg::RESULT_W-1:0];
        end
        else if (c_neg_reg)
        begin
            result = ~quo_ext;
        end
        else
        begin
            result = quo_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            c_valid_reg <= c_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_valid && c_advance)
        begin
            c_word_reg  <= pop_word;
            c_mag_reg   <= mag;
            c_neg_reg   <= num[jcq_pkg::COEFF_W];
            c_recip_reg <= recip_rom[pop_word.step];
        end
        if (c_valid_reg && o_advance)
        begin
            o_result_reg <= result;
            o_step_reg   <= c_word_reg.step;
        end
    end

    assign out_valid    = o_valid_reg;
    assign result_value = o_result_reg;
    assign step_size    = o_step_reg;

endmodule
